// File: hw/rtl/tws_pkg.sv
// Shared types and address constants for the timer write-status shadow block.
// No dependencies; used by tws_status and timer_write_status_shadow.
package tws_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OffW  = 12;
  localparam int unsigned GlbW  = 17;
  localparam int unsigned CntW  = 2;
  localparam int unsigned LocW  = 4;

  // Global region map.
  localparam logic [OffW-1:0] LocalRegionBase = 12'h300;
  localparam logic [OffW-1:0] CntSetBase      = 12'h100;
  localparam logic [OffW-1:0] CntSetEnd       = 12'h108;
  localparam logic [OffW-1:0] CntStatusOff    = 12'h110;
  localparam logic [OffW-1:0] GlbSetBase      = 12'h200;
  localparam logic [OffW-1:0] GlbSetEnd       = 12'h244;
  localparam logic [OffW-1:0] GlbStatusOff    = 12'h24C;

  // Local timer window: one 0x100 page per timer, starting at page 3.
  localparam logic [3:0] LocalFirstPage = 4'h3;
  localparam logic [7:0] LocCmpLoOff    = 8'h00;
  localparam logic [7:0] LocCmpHiOff    = 8'h08;
  localparam logic [7:0] LocCtrlOff     = 8'h20;
  localparam logic [7:0] LocStatusOff   = 8'h40;
  localparam int unsigned LocCmpBit     = 1;
  localparam int unsigned LocCtrlBit    = 3;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // One decoded bus access as handed to the status registers.
  typedef struct packed {
    logic             is_write;
    logic [OffW-1:0]  offset;
    logic [DataW-1:0] clr;
  } access_t;

endpackage

// File: hw/rtl/tws_status.sv
// Shadow status registers with address decode, set/clear updates and read mux.
// Depends on tws_pkg.
module tws_status #(
  parameter int unsigned LOCAL_TIMERS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc_en,
  input  tws_pkg::access_t           acc,
  output logic [tws_pkg::DataW-1:0]  rd_data
);

  logic [tws_pkg::GlbW-1:0] glb_status_r, glb_status_nxt;
  logic [tws_pkg::CntW-1:0] cnt_status_r, cnt_status_nxt;
  logic [tws_pkg::LocW-1:0] loc_status_r   [LOCAL_TIMERS];
  logic [tws_pkg::LocW-1:0] loc_status_nxt [LOCAL_TIMERS];
  logic [LOCAL_TIMERS-1:0]  loc_hit;
  logic [tws_pkg::DataW-1:0] loc_rd [LOCAL_TIMERS];

  logic       in_global;
  logic [7:0] loff;
  logic       wr;

  assign in_global = acc.offset < tws_pkg::LocalRegionBase;
  assign loff      = acc.offset[7:0];
  assign wr        = acc.is_write;

  always_comb begin
    cnt_status_nxt = cnt_status_r;
    glb_status_nxt = glb_status_r;
    if (wr && in_global) begin
      priority if (acc.offset >= tws_pkg::CntSetBase && acc.offset < tws_pkg::CntSetEnd) begin
        cnt_status_nxt = cnt_status_r | (tws_pkg::CntW'(1) << acc.offset[2]);
      end else if (acc.offset == tws_pkg::CntStatusOff) begin
        cnt_status_nxt = cnt_status_r & ~acc.clr[tws_pkg::CntW-1:0];
      end else if (acc.offset >= tws_pkg::GlbSetBase && acc.offset < tws_pkg::GlbSetEnd) begin
        glb_status_nxt = glb_status_r | (tws_pkg::GlbW'(1) << acc.offset[6:2]);
      end else if (acc.offset == tws_pkg::GlbStatusOff) begin
        glb_status_nxt = glb_status_r & ~acc.clr[tws_pkg::GlbW-1:0];
      end else begin
        cnt_status_nxt = cnt_status_r;
      end
    end
  end

  for (genvar i = 0; i < LOCAL_TIMERS; i++) begin : g_local
    // Each timer owns one page of the window; pages beyond the last timer match nothing.
    assign loc_hit[i] = (acc.offset[11:8] == tws_pkg::LocalFirstPage + 4'(i)) && !in_global;

    always_comb begin
      loc_status_nxt[i] = loc_status_r[i];
      if (wr && loc_hit[i]) begin
        priority if (loff == tws_pkg::LocCmpLoOff || loff == tws_pkg::LocCmpHiOff) begin
          loc_status_nxt[i] = loc_status_r[i] | tws_pkg::LocW'(1 << tws_pkg::LocCmpBit);
        end else if (loff == tws_pkg::LocCtrlOff) begin
          loc_status_nxt[i] = loc_status_r[i] | tws_pkg::LocW'(1 << tws_pkg::LocCtrlBit);
        end else if (loff == tws_pkg::LocStatusOff) begin
          loc_status_nxt[i] = loc_status_r[i] & ~acc.clr[tws_pkg::LocW-1:0];
        end else begin
          loc_status_nxt[i] = loc_status_r[i];
        end
      end
    end

    assign loc_rd[i] = (loc_hit[i] && loff == tws_pkg::LocStatusOff)
                       ? tws_pkg::DataW'(loc_status_r[i]) : '0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        loc_status_r[i] <= '0;
      end else if (acc_en) begin
        loc_status_r[i] <= loc_status_nxt[i];
      end
    end
  end

  always_comb begin
    rd_data = '0;
    if (!wr) begin
      if (acc.offset == tws_pkg::CntStatusOff) begin
        rd_data = tws_pkg::DataW'(cnt_status_r);
      end else if (acc.offset == tws_pkg::GlbStatusOff) begin
        rd_data = tws_pkg::DataW'(glb_status_r);
      end
      for (int i = 0; i < LOCAL_TIMERS; i++) begin
        rd_data = rd_data | loc_rd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glb_status_r <= '0;
      cnt_status_r <= '0;
    end else if (acc_en) begin
      glb_status_r <= glb_status_nxt;
      cnt_status_r <= cnt_status_nxt;
    end
  end

endmodule

// File: hw/rtl/timer_write_status_shadow.sv
// Top level of the timer write-status shadow block: input stage, status
// registers and output register. Depends on tws_pkg and tws_status.
//
// Usage:
//   Each input beat is one bus access to the timer register window: in_cmd
//   (0 read, 1 write), a 12-bit byte offset, the write data and a bit mask.
//   Every accepted beat yields exactly one output beat carrying read data,
//   which is the addressed status register for a read of a status offset
//   and zero for writes and all other reads.
//   Beats are taken into an input register, then the decode, the set/clear
//   update of the shadow status registers and the read mux run combinationally
//   as the beat moves into the output register. Throughput is one access per
//   cycle while the output is not stalled.
//   A stalled output (out_valid high, out_ready low) holds its beat; the
//   input register still takes one more beat, after which in_ready drops
//   until the output drains. State changes happen in accepted order, so a
//   read always sees every earlier write.
//   Reset (rst_n low, synchronous) clears all status registers and empties
//   both stages; in_ready is high in the first cycle after reset.
module timer_write_status_shadow #(
  parameter int unsigned LOCAL_TIMERS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [tws_pkg::OffW-1:0]    in_offset,
  input  logic [tws_pkg::DataW-1:0]   in_write_data,
  input  logic [tws_pkg::DataW-1:0]   in_byte_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tws_pkg::DataW-1:0]   out_read_data
);

  // Input stage.
  logic                      s1_valid_r, s1_valid_nxt;
  tws_pkg::access_t          s1_acc_r;
  logic                      s1_adv;
  logic                      in_fire;

  // Output stage.
  logic                      out_valid_r, out_valid_nxt;
  logic [tws_pkg::DataW-1:0] out_data_r;

  logic [tws_pkg::DataW-1:0] rd_data;
  logic                      acc_en;

  // The input stage moves on whenever the output register is empty or draining.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign acc_en   = s1_valid_r && s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers; the clear mask is formed on the way in.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc_r.is_write <= (in_cmd == tws_pkg::CMD_WRITE);
      s1_acc_r.offset   <= in_offset;
      s1_acc_r.clr      <= in_write_data & in_byte_mask;
    end
    if (acc_en) begin
      out_data_r <= rd_data;
    end
  end

  tws_status #(
    .LOCAL_TIMERS(LOCAL_TIMERS)
  ) u_status (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (acc_en),
    .acc     (s1_acc_r),
    .rd_data (rd_data)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

// File: hw/rtl/tws_checker.sv
// Port-level checker for timer_write_status_shadow, attached by bind.
// Depends on tws_pkg for widths only.
module tws_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tws_pkg::DataW-1:0]  out_read_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result beat keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data))
    else $error("out_read_data changed while stalled");

  // Both stages are empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // With nothing waiting at the output, the block never blocks its input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // A result cannot appear without an earlier accepted beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid, 1) ||
                         $past(in_valid, 1) || $past(in_valid, 2))
    else $error("result without input beat");

endmodule

bind timer_write_status_shadow tws_checker u_tws_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for timer_write_status_shadow: random and directed bus accesses
// are checked against an in-bench model of the shadow status registers.
// Depends on tws_pkg and on the RTL of the block only.
module testbench;
  import tws_pkg::*;

  localparam int unsigned LocalTimers = 4;
  // Length of the deliberate output hold-off that backs the block up.
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned MaxReports  = 10;

  // The scoreboard keeps its own copy of the status registers. Every
  // accepted access updates that copy in acceptance order and queues the
  // read data that the access must return. Each output beat is matched
  // against the oldest queued word.
  class status_board;
    logic [GlbW-1:0]  glb_stat;
    logic [CntW-1:0]  cnt_stat;
    logic [LocW-1:0]  loc_stat [LocalTimers];
    logic [DataW-1:0] read_data_due [$];
    int unsigned      mismatches;
    int unsigned      strays;
    int unsigned      checked;
    int unsigned      reads_seen;
    int unsigned      writes_seen;

    function new();
      glb_stat    = '0;
      cnt_stat    = '0;
      foreach (loc_stat[i]) loc_stat[i] = '0;
      mismatches  = 0;
      strays      = 0;
      checked     = 0;
      reads_seen  = 0;
      writes_seen = 0;
    endfunction

    // Applies one access to the model state and returns the read data.
    function logic [DataW-1:0] predict_read_data(cmd_t cmd, logic [OffW-1:0] off,
                                                 logic [DataW-1:0] data,
                                                 logic [DataW-1:0] mask);
      logic [DataW-1:0] clear_bits;
      logic [DataW-1:0] rd;
      logic [OffW-1:0]  rel;
      logic [7:0]       page_off;
      int unsigned      timer;
      clear_bits = data & mask;
      rd = '0;
      if (off < LocalRegionBase) begin
        if (cmd == CMD_WRITE) begin
          if (off >= CntSetBase && off < CntSetEnd) begin
            cnt_stat[int'((off - CntSetBase) >> 2)] = 1'b1;
          end else if (off == CntStatusOff) begin
            cnt_stat &= ~clear_bits[CntW-1:0];
          end else if (off >= GlbSetBase && off < GlbSetEnd) begin
            glb_stat[int'((off - GlbSetBase) >> 2)] = 1'b1;
          end else if (off == GlbStatusOff) begin
            glb_stat &= ~clear_bits[GlbW-1:0];
          end
        end else if (off == CntStatusOff) begin
          rd = DataW'(cnt_stat);
        end else if (off == GlbStatusOff) begin
          rd = DataW'(glb_stat);
        end
      end else begin
        rel      = off - LocalRegionBase;
        timer    = int'(rel >> 8);
        page_off = rel[7:0];
        // Pages past the last implemented timer are dead: no update, zero read.
        if (timer < LocalTimers) begin
          if (cmd == CMD_WRITE) begin
            if (page_off == LocCmpLoOff || page_off == LocCmpHiOff) begin
              loc_stat[timer][LocCmpBit] = 1'b1;
            end else if (page_off == LocCtrlOff) begin
              loc_stat[timer][LocCtrlBit] = 1'b1;
            end else if (page_off == LocStatusOff) begin
              loc_stat[timer] &= ~clear_bits[LocW-1:0];
            end
          end else if (page_off == LocStatusOff) begin
            rd = DataW'(loc_stat[timer]);
          end
        end
      end
      return rd;
    endfunction

    function void note_access(cmd_t cmd, logic [OffW-1:0] off,
                              logic [DataW-1:0] data, logic [DataW-1:0] mask);
      if (cmd == CMD_WRITE) writes_seen++;
      else reads_seen++;
      read_data_due.push_back(predict_read_data(cmd, off, data, mask));
    endfunction

    function void check_read_data(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      if (read_data_due.size() == 0) begin
        strays++;
        if (mismatches + strays <= MaxReports)
          $display("%0t: output beat with nothing outstanding, read_data=%h", $time, got);
        return;
      end
      want = read_data_due.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches + strays <= MaxReports)
          $display("%0t: read_data mismatch, expected %h, got %h", $time, want, got);
      end
    endfunction

    function int unsigned pending();
      return read_data_due.size();
    endfunction
  endclass

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic             in_cmd        = 1'b0;
  logic [OffW-1:0]  in_offset     = '0;
  logic [DataW-1:0] in_write_data = '0;
  logic [DataW-1:0] in_byte_mask  = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [DataW-1:0] out_read_data;

  // Percent chances of a sender idle cycle and a receiver stall cycle.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  // The stimulus bumps hold_ticket to ask the receiver for a long hold-off.
  int unsigned hold_ticket = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned late_leftovers = 0;
  bit          drain_timeout  = 1'b0;

  status_board board;

  timer_write_status_shadow #(
    .LOCAL_TIMERS(LocalTimers)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_offset    (in_offset),
    .in_write_data(in_write_data),
    .in_byte_mask (in_byte_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver. Right after the edge the outputs still hold their pre-edge
  // values, so the handshake test here sees exactly what the block saw.
  // out_ready is chosen for the next cycle: low during a requested hold-off,
  // otherwise random according to the current stall rate.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_read_data(out_read_data);
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one beat, with random idle cycles in front of it, and holds it
  // until the block takes it. The model is updated at the accepting edge.
  task automatic send_access(input cmd_t cmd, input logic [OffW-1:0] off,
                             input logic [DataW-1:0] data, input logic [DataW-1:0] mask);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_offset     <= off;
    in_write_data <= data;
    in_byte_mask  <= mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_access(cmd, off, data, mask);
  endtask

  // Stops offering and waits until every queued read data word has come out.
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (board.pending() != 0) drain_timeout = 1'b1;
  endtask

  // Data and mask words: all ones, single bits and random values, some of them sparse.
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(3))
      0: return '1;
      1: return DataW'(1) << $urandom_range(DataW - 1);
      2: return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Most offsets hit a mapped register (sometimes a byte off alignment) so
  // that the status state keeps moving; the rest cover the whole window.
  function automatic logic [OffW-1:0] pick_offset();
    logic [OffW-1:0] page;
    page = LocalRegionBase + (OffW'($urandom_range(LocalTimers - 1)) << 8);
    // Now and then address a page beyond the implemented timers.
    if ($urandom_range(9) == 0) page = LocalRegionBase + (OffW'($urandom_range(12)) << 8);
    case ($urandom_range(11))
      0:       return CntSetBase + OffW'($urandom_range(7));
      1:       return GlbSetBase + OffW'($urandom_range(int'(GlbSetEnd - GlbSetBase) - 1));
      2, 3:    return CntStatusOff;
      4, 5:    return GlbStatusOff;
      6:       return page + OffW'($urandom_range(1) ? LocCmpLoOff : LocCmpHiOff);
      7:       return page + OffW'(LocCtrlOff);
      8, 9:    return page + OffW'(LocStatusOff);
      10:      return OffW'($urandom()) ^ OffW'($urandom_range(1));
      default: return OffW'($urandom());
    endcase
  endfunction

  task automatic random_phase(input int unsigned count, input int unsigned sender_idle,
                              input int unsigned receiver_stall, input bit with_hold);
    cmd_t cmd;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int unsigned n = 0; n < count; n++) begin
      // Halfway through, freeze the receiver while the sender keeps going,
      // so the output and input registers fill and in_ready drops.
      if (with_hold && n == count / 2) hold_ticket <= hold_ticket + 1;
      cmd = ($urandom_range(99) < 45) ? CMD_READ : CMD_WRITE;
      send_access(cmd, pick_offset(), pick_word(), pick_word());
    end
    wait_drained();
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: the counter, global and first timer status registers read
    // at reset, every set range at both ends, clears through data and mask,
    // unaligned and unmapped offsets, dead timer pages and the top of the window.
    send_access(CMD_READ,  CntStatusOff, '0, '0);
    send_access(CMD_READ,  GlbStatusOff, '1, '1);
    send_access(CMD_READ,  12'h340, '0, '0);
    send_access(CMD_WRITE, CntSetBase, '0, '0);
    send_access(CMD_WRITE, CntSetEnd - 1, '1, '1);
    send_access(CMD_WRITE, CntSetEnd, '1, '1);
    send_access(CMD_READ,  CntStatusOff, '0, '0);
    send_access(CMD_WRITE, GlbSetBase, '0, '0);
    send_access(CMD_WRITE, GlbSetEnd - 1, '0, '0);
    send_access(CMD_WRITE, 12'h222, '0, '0);
    send_access(CMD_WRITE, GlbSetEnd, '1, '1);
    send_access(CMD_READ,  GlbStatusOff, '0, '0);
    // Clears need a one in both data and mask.
    send_access(CMD_WRITE, CntStatusOff, 32'h0000_0001, '1);
    send_access(CMD_WRITE, GlbStatusOff, '1, 32'h0001_0000);
    send_access(CMD_WRITE, GlbStatusOff, '0, '1);
    send_access(CMD_READ,  GlbStatusOff, '0, '0);
    send_access(CMD_WRITE, 12'h300, '0, '0);
    send_access(CMD_WRITE, 12'h320, '0, '0);
    send_access(CMD_WRITE, 12'h341, '1, '1);
    send_access(CMD_WRITE, 12'h340, 32'h0000_0002, 32'hFFFF_FFFE);
    send_access(CMD_READ,  12'h340, '0, '0);
    send_access(CMD_WRITE, 12'h608, '0, '0);
    send_access(CMD_READ,  12'h640, '0, '0);
    send_access(CMD_WRITE, 12'h700, '0, '0);
    send_access(CMD_READ,  12'h740, '0, '0);
    send_access(CMD_WRITE, 12'hFFF, '1, '1);
    send_access(CMD_READ,  12'h111, '0, '0);
    send_access(CMD_READ,  12'h000, '0, '0);
    send_access(CMD_READ,  12'hFFF, '0, '0);
    wait_drained();

    // Random beats under four handshake mixes; the first one also carries
    // the long output hold-off.
    random_phase(RandomItems / 4, 0, 0, 1'b1);
    random_phase(RandomItems / 4, 60, 0, 1'b0);
    random_phase(RandomItems / 4, 0, 60, 1'b0);
    random_phase(RandomItems / 4, 26, 26, 1'b0);

    // Let any beat that should not exist show up before the final count.
    stall_pct = 0;
    repeat (8) @(posedge clk);
    late_leftovers = board.pending();

    $display("Ran %0d accesses (%0d reads, %0d writes), %0d beats checked,",
             board.reads_seen + board.writes_seen, board.reads_seen, board.writes_seen,
             board.checked);
    $display("over four idle/stall mixes plus a %0d-cycle output hold-off.", HoldCycles);
    if (board.mismatches == 0 && board.strays == 0 && late_leftovers == 0 && !drain_timeout)
    begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d unexpected beats, %0d beats never delivered",
               board.mismatches, board.strays, late_leftovers);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("Watchdog expired with %0d beats outstanding", board.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
